>>> hw/rtl/isw_pkg.sv
// Shared types and constants for the IMU sliding-window average block.
// No dependencies; every other file in hw/rtl imports this package.
package isw_pkg;

   // Field widths of the sample and result beats.
   localparam int SAMPLE_W     = 16;
   localparam int ACCEL_MEAN_W = 16;
   localparam int RATE_MEAN_W  = 26;

   // A truncated window mean of 16-bit samples has a magnitude of at most 2^15.
   localparam int QUO_W = 16;

   // Gyro means are scaled by this factor to give deg/s in Q14.
   localparam int RATE_SCALE = 1000;
   localparam int ACCEL_SCALE = 1;

   // Register stages from the accepted beat to the result register.
   localparam int NUM_STAGES = 5;

   typedef logic signed [SAMPLE_W-1:0]    sample_type;
   typedef logic signed [RATE_MEAN_W-1:0] lane_mean_type;

   // Pipeline control broadcast from the control unit to every lane.
   typedef struct packed {
      logic                  take;  // a sample beat is accepted this cycle
      logic [NUM_STAGES-1:0] en;    // stage k loads when en[k] is high
   } pipe_ctrl_type;

endpackage

>>> hw/rtl/isw_req_if.sv
// Sample channel interface: valid/ready handshake plus six raw IMU readings.
// Depends on isw_pkg.
interface isw_req_if;
   import isw_pkg::*;

   logic       valid;
   logic       ready;
   sample_type accel_x;
   sample_type accel_y;
   sample_type accel_z;
   sample_type rate_x;
   sample_type rate_y;
   sample_type rate_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   output rate_x, output rate_y, output rate_z, input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                   input rate_x, input rate_y, input rate_z, output ready);
endinterface

>>> hw/rtl/isw_rsp_if.sv
// Result channel interface: valid/ready handshake plus six window means.
// Depends on isw_pkg.
interface isw_rsp_if;
   import isw_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [ACCEL_MEAN_W-1:0] accel_mean_x;
   logic signed [ACCEL_MEAN_W-1:0] accel_mean_y;
   logic signed [ACCEL_MEAN_W-1:0] accel_mean_z;
   logic signed [RATE_MEAN_W-1:0]  rate_mean_x;
   logic signed [RATE_MEAN_W-1:0]  rate_mean_y;
   logic signed [RATE_MEAN_W-1:0]  rate_mean_z;

   modport source (output valid, output accel_mean_x, output accel_mean_y,
                   output accel_mean_z, output rate_mean_x, output rate_mean_y,
                   output rate_mean_z, input ready);
   modport sink   (input valid, input accel_mean_x, input accel_mean_y,
                   input accel_mean_z, input rate_mean_x, input rate_mean_y,
                   input rate_mean_z, output ready);
endinterface

>>> hw/rtl/isw_ctrl.sv
// Pipeline control: per-stage valid bits and bubble-collapsing load enables.
// Depends on isw_pkg.
module isw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_ready,
   output logic                  req_ready,
   output logic                  rsp_valid,
   output isw_pkg::pipe_ctrl_type ctrl
);
   import isw_pkg::*;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] en;
   logic                  take;

   // A stage may load when it is empty or when its content moves on.
   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign take = req_valid && en[0];

   always_comb begin
      vld_in[0] = en[0] ? take : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign ctrl.take = take;
   assign ctrl.en   = en;

endmodule

>>> hw/rtl/isw_lane.sv
// One axis of the filter: delay line, running sum, reciprocal division and scaling.
// Depends on isw_pkg; driven by the control struct from isw_ctrl.
module isw_lane #(
   parameter int WIN   = 5,
   parameter int SCALE = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  isw_pkg::pipe_ctrl_type ctrl,
   input  isw_pkg::sample_type    sample,
   output isw_pkg::lane_mean_type mean
);
   import isw_pkg::*;

   localparam int LOG_W   = $clog2(WIN);
   localparam int SUM_W   = SAMPLE_W + LOG_W;
   localparam int SH      = SUM_W + LOG_W;
   localparam int RECIP_W = SH + 1;
   localparam longint unsigned RECIP_L =
      ((64'd1 << SH) + 64'(WIN) - 64'd1) / 64'(WIN);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int SCL_W   = RATE_MEAN_W - 1;

   logic signed [SUM_W-1:0] run_ff;
   logic signed [SUM_W-1:0] run_in;
   logic signed [SUM_W-1:0] oldest;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0]        mag_ff;
   logic [SUM_W-1:0]        mag_in;
   logic [PROD_W-1:0]       prod;
   logic [QUO_W-1:0]        quo_ff;
   logic [QUO_W-1:0]        quo_in;
   logic [SCL_W-1:0]        scl_ff;
   logic [SCL_W-1:0]        scl_in;
   logic [2:0]              neg_ff;
   logic                    neg_in;
   lane_mean_type           mean_ff;
   lane_mean_type           mean_in;

   // The delay line holds the previous WIN-1 samples; the newest sits at entry 0.
   if (WIN > 1) begin : g_hist
      sample_type hist_ff [WIN-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            for (int i = 0; i < WIN - 1; i++) begin
               hist_ff[i] <= '0;
            end
         end else if (ctrl.take) begin
            hist_ff[0] <= sample;
            for (int i = 1; i < WIN - 1; i++) begin
               hist_ff[i] <= hist_ff[i-1];
            end
         end
      end

      assign oldest = SUM_W'(hist_ff[WIN-2]);
   end else begin : g_nohist
      assign oldest = '0;
   end

   // run_ff is the sum of the delay line; it stays zero for a window of one.
   assign run_in = (WIN > 1) ? (run_ff + SUM_W'(sample) - oldest) : '0;
   assign sum_in = run_ff + SUM_W'(sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else if (ctrl.take) begin
         run_ff <= run_in;
      end
   end

   // Divide the magnitude, so truncation goes toward zero once the sign returns.
   assign neg_in = sum_ff[SUM_W-1];
   assign mag_in = neg_in ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign prod   = PROD_W'(mag_ff) * PROD_W'(RECIP);
   assign quo_in = prod[SH +: QUO_W];
   assign scl_in = SCL_W'(quo_ff) * SCL_W'(SCALE);
   assign mean_in = neg_ff[2] ? -$signed({1'b0, scl_ff}) : $signed({1'b0, scl_ff});

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         sum_ff <= sum_in;
      end
      if (ctrl.en[1]) begin
         mag_ff    <= mag_in;
         neg_ff[0] <= neg_in;
      end
      if (ctrl.en[2]) begin
         quo_ff    <= quo_in;
         neg_ff[1] <= neg_ff[0];
      end
      if (ctrl.en[3]) begin
         scl_ff    <= scl_in;
         neg_ff[2] <= neg_ff[1];
      end
      if (ctrl.en[4]) begin
         mean_ff <= mean_in;
      end
   end

   assign mean = mean_ff;

endmodule

>>> hw/rtl/imu_sliding_window_average_top.sv
// IMU sliding-window average: six boxcar filters, one per sensor axis.
// A sample beat passes the sum, magnitude, quotient, scaled and mean registers in order
// before it is offered as a result beat. Throughput: one sample beat per cycle while
// the result side is not stalled; the rate is set by the running-sum register of each
// lane, which folds in the new sample and drops the oldest.
// Reset (synchronous, active high) zeroes every delay line and running sum and
// empties the pipeline; the first beat after reset may come in the next cycle.
module imu_sliding_window_average_top #(
   parameter int ACC_WINDOW  = 5,
   parameter int GYRO_WINDOW = 20
) (
   input logic        clock,
   input logic        reset,
   isw_req_if.sink    req_ch,
   isw_rsp_if.source  rsp_ch
);
   import isw_pkg::*;

   localparam int NUM_AXES_LOCAL = 3;

   pipe_ctrl_type ctrl;
   lane_mean_type accel_mean [NUM_AXES_LOCAL];
   lane_mean_type rate_mean  [NUM_AXES_LOCAL];
   sample_type    accel_in   [NUM_AXES_LOCAL];
   sample_type    rate_in    [NUM_AXES_LOCAL];

   // The control unit keeps one valid bit per stage. A stage loads whenever it is
   // empty or its content moves on, so bubbles collapse and a new sample beat is
   // taken even while a finished result beat waits in the output register, if an earlier stage is empty.
   isw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .ctrl      (ctrl)
   );

   assign accel_in[0] = req_ch.accel_x;
   assign accel_in[1] = req_ch.accel_y;
   assign accel_in[2] = req_ch.accel_z;
   assign rate_in[0]  = req_ch.rate_x;
   assign rate_in[1]  = req_ch.rate_y;
   assign rate_in[2]  = req_ch.rate_z;

   // Six lanes run in lockstep under the same enables. Accelerometer lanes pass the
   // mean through unscaled, since raw counts already read as g in Q14. Gyro lanes
   // multiply the truncated mean by 1000 to give deg/s in Q14.
   for (genvar a = 0; a < NUM_AXES_LOCAL; a++) begin : g_axis
      isw_lane #(
         .WIN   (ACC_WINDOW),
         .SCALE (ACCEL_SCALE)
      ) u_accel_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .sample (accel_in[a]),
         .mean   (accel_mean[a])
      );

      isw_lane #(
         .WIN   (GYRO_WINDOW),
         .SCALE (RATE_SCALE)
      ) u_rate_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .sample (rate_in[a]),
         .mean   (rate_mean[a])
      );
   end

   // Merge: the lane output registers together form the result beat. An
   // accelerometer mean always fits 16 bits, so the upper bits are dropped.
   assign rsp_ch.accel_mean_x = accel_mean[0][ACCEL_MEAN_W-1:0];
   assign rsp_ch.accel_mean_y = accel_mean[1][ACCEL_MEAN_W-1:0];
   assign rsp_ch.accel_mean_z = accel_mean[2][ACCEL_MEAN_W-1:0];
   assign rsp_ch.rate_mean_x  = rate_mean[0];
   assign rsp_ch.rate_mean_y  = rate_mean[1];
   assign rsp_ch.rate_mean_z  = rate_mean[2];

endmodule

>>> hw/rtl/isw_checker.sv
// Port-level checker for the IMU sliding-window average, bound to the top level.
// Depends on isw_pkg and on the port names of imu_sliding_window_average_top.
module isw_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [isw_pkg::ACCEL_MEAN_W-1:0] accel_mean_x,
   input logic signed [isw_pkg::RATE_MEAN_W-1:0]  rate_mean_x
);
   import isw_pkg::*;

   logic [3:0] pend_ff;
   logic [3:0] pend_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;
   assign pend_in  = pend_ff + 4'(req_beat) - 4'(rsp_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A result beat held back by the sink stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   // With no result pending at the output, the block must take a sample beat.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("sample beat refused with an empty output register");

   // Beats in flight never exceed the pipeline depth.
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 4'(NUM_STAGES))
      else $error("more beats in flight than pipeline stages");

   // A result beat is only offered for a sample beat taken earlier.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 4'd0)
      else $error("result beat without a matching sample beat");

   // A stalled result beat keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(accel_mean_x) && $stable(rate_mean_x))
      else $error("result payload changed while stalled");

endmodule

bind imu_sliding_window_average_top isw_checker u_isw_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .accel_mean_x (rsp_ch.accel_mean_x),
   .rate_mean_x  (rsp_ch.rate_mean_x)
);

>>> bench/imu_sliding_window_average_top_tb.sv
// Self-checking testbench for the IMU sliding-window average block.
// Depends on isw_pkg, isw_req_if, isw_rsp_if and imu_sliding_window_average_top.
module imu_sliding_window_average_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import isw_pkg::*;

   // Window lengths used for this instance. The filter model below also
   // handles a window of one, where the mean is the sample itself.
   localparam int ACC_WINDOW  = 5;
   localparam int GYRO_WINDOW = 20;

   localparam int NUM_AXES    = 6;
   localparam int NUM_ACCEL   = 3;
   localparam int MAX_WINDOW  = 64;
   localparam int GYRO_SCALE  = 1000;

   localparam int RANDOM_ITEMS   = 1500;
   localparam int HOLD_ITEMS     = 120;
   localparam int HOLD_CYCLES    = 400;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int MAX_REPORTED   = 10;

   localparam sample_type SAMPLE_MIN = 16'sh8000;
   localparam sample_type SAMPLE_MAX = 16'sh7fff;

   // One sample beat: three accelerometer and three gyro readings.
   typedef struct packed {
      sample_type accel_x;
      sample_type accel_y;
      sample_type accel_z;
      sample_type rate_x;
      sample_type rate_y;
      sample_type rate_z;
   } sample_set_type;

   // One result beat: the six window means.
   typedef struct packed {
      logic signed [ACCEL_MEAN_W-1:0] accel_mean_x;
      logic signed [ACCEL_MEAN_W-1:0] accel_mean_y;
      logic signed [ACCEL_MEAN_W-1:0] accel_mean_z;
      logic signed [RATE_MEAN_W-1:0]  rate_mean_x;
      logic signed [RATE_MEAN_W-1:0]  rate_mean_y;
      logic signed [RATE_MEAN_W-1:0]  rate_mean_z;
   } mean_set_type;

   // Kinds of random sample content.
   typedef enum int {VAL_ANY, VAL_EXTREME, VAL_NEAR_ZERO} value_kind_type;

   // Receiver behaviors between long hold-offs.
   typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_type;

   logic clock;
   logic reset;

   isw_req_if req_ch();
   isw_rsp_if rsp_ch();

   imu_sliding_window_average_top #(
      .ACC_WINDOW  (ACC_WINDOW),
      .GYRO_WINDOW (GYRO_WINDOW)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Delay lines of the filter model, one row per axis. Only the first
   // window-1 entries of a row are used; they start at zero like the block's.
   int axis_history[NUM_AXES][MAX_WINDOW] = '{default: 0};

   // Means predicted for accepted sample beats, oldest first.
   mean_set_type pending_means[$];

   int failures      = 0;
   int results_seen  = 0;
   int cycle_count   = 0;

   // Sender burst bookkeeping.
   int burst_left    = 0;
   bit gaps_enabled  = 1'b1;

   // Receiver control: a test raises hold_off_request and the receiver
   // process turns it into a counted stretch of cycles with ready low.
   bit             hold_off_request = 1'b0;
   int             hold_left        = 0;
   ready_mode_type ready_mode       = READY_ALWAYS;
   int             mode_left        = 0;
   int             pattern_phase    = 0;

   // 12 ns clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Global cycle count and the run-time limit. The limit is far above the
   // slowest legal run: every beat waiting out the longest sender gap and
   // receiver stalls, plus the long hold-offs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Running mean of one axis: the new sample plus the last win-1 samples,
   // divided by the window with truncation toward zero. The sample is then
   // pushed into the delay line and the oldest one falls off.
   function automatic int boxcar_mean(input int axis, input int win, input int x);
      int sum;
      int i;
      sum = x;
      for (i = 0; i < win - 1; i++)
         sum += axis_history[axis][i];
      for (i = win - 2; i > 0; i--)
         axis_history[axis][i] = axis_history[axis][i - 1];
      if (win > 1)
         axis_history[axis][0] = x;
      return sum / win;
   endfunction

   // Filter model: advances every delay line by one sample beat and returns
   // the result beat the block must produce for it.
   function automatic mean_set_type filter_sample(input sample_set_type s);
      int           raw [NUM_AXES];
      int           mean[NUM_AXES];
      mean_set_type r;
      raw[0] = int'(s.accel_x);
      raw[1] = int'(s.accel_y);
      raw[2] = int'(s.accel_z);
      raw[3] = int'(s.rate_x);
      raw[4] = int'(s.rate_y);
      raw[5] = int'(s.rate_z);
      for (int a = 0; a < NUM_AXES; a++)
         mean[a] = boxcar_mean(a, (a < NUM_ACCEL) ? ACC_WINDOW : GYRO_WINDOW, raw[a]);
      // Accelerometer counts are already g in Q14; gyro means get the x1000 scale.
      r.accel_mean_x = ACCEL_MEAN_W'(mean[0]);
      r.accel_mean_y = ACCEL_MEAN_W'(mean[1]);
      r.accel_mean_z = ACCEL_MEAN_W'(mean[2]);
      r.rate_mean_x  = RATE_MEAN_W'(mean[3] * GYRO_SCALE);
      r.rate_mean_y  = RATE_MEAN_W'(mean[4] * GYRO_SCALE);
      r.rate_mean_z  = RATE_MEAN_W'(mean[5] * GYRO_SCALE);
      return r;
   endfunction

   function automatic void report_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTED)
         $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   function automatic sample_type pick_value(input value_kind_type kind);
      case (kind)
         VAL_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return SAMPLE_MIN;
               1:       return SAMPLE_MAX;
               2:       return sample_type'(SAMPLE_MIN + 1);
               default: return '0;
            endcase
         end
         // Small values around zero, where truncation toward zero differs
         // from rounding down.
         VAL_NEAR_ZERO: return sample_type'(int'($urandom_range(0, 60)) - 30);
         default:       return sample_type'($urandom);
      endcase
   endfunction

   function automatic sample_set_type make_sample(input value_kind_type kind);
      sample_set_type s;
      s.accel_x = pick_value(kind);
      s.accel_y = pick_value(kind);
      s.accel_z = pick_value(kind);
      s.rate_x  = pick_value(kind);
      s.rate_y  = pick_value(kind);
      s.rate_z  = pick_value(kind);
      return s;
   endfunction

   // Offers one sample beat and returns at the edge where it is accepted.
   // The sender works in bursts; between bursts valid drops for a random
   // gap. Valid stays high after the beat so that a burst runs back to back;
   // go_idle lowers it when a phase ends.
   task automatic send_sample(input sample_set_type s);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_enabled ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_ch.valid   <= 1'b1;
      req_ch.accel_x <= s.accel_x;
      req_ch.accel_y <= s.accel_y;
      req_ch.accel_z <= s.accel_z;
      req_ch.rate_x  <= s.rate_x;
      req_ch.rate_y  <= s.rate_y;
      req_ch.rate_z  <= s.rate_z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_means.push_back(filter_sample(s));
      burst_left--;
   endtask

   task automatic go_idle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
   endtask

   // Always lets at least one edge pass, so a following send never raises
   // valid in the same time step in which go_idle lowered it.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_means.size() != 0) @(posedge clock);
   endtask

   // Directed part: start-up with zeros still in the delay lines (small
   // negative sums must truncate toward zero), then full windows of the most
   // negative sample, then the most positive sample sliding in.
   task automatic test_startup_and_extremes();
      sample_set_type s;
      s = '{accel_x: -4, accel_y: 4, accel_z: 5, rate_x: -19, rate_y: 20, rate_z: -21};
      send_sample(s);
      s = '{accel_x: -1, accel_y: -6, accel_z: 9, rate_x: 1, rate_y: -40, rate_z: 19};
      send_sample(s);
      s = '{default: SAMPLE_MIN};
      repeat (GYRO_WINDOW) send_sample(s);
      s = '{default: SAMPLE_MAX};
      repeat (3) send_sample(s);
      go_idle();
      wait_drained();
   endtask

   // Random part: runs of constant extremes long enough to fill the gyro window,
   // runs of near-zero values and, most often, stretches of arbitrary samples.
   // Every few hundred beats the sender stops until all results are back.
   task automatic test_random_stream(input int num_items);
      sample_set_type s;
      int             sent;
      int             run_len;
      int             next_pause;
      int             choice;
      sent       = 0;
      next_pause = 400;
      while (sent < num_items) begin
         if ($urandom_range(0, 3) == 0)
            gaps_enabled = ~gaps_enabled;
         choice = $urandom_range(0, 9);
         if (choice < 2) begin
            // Constant extremes long enough to fill the gyro window.
            s       = make_sample(VAL_EXTREME);
            run_len = $urandom_range(GYRO_WINDOW, GYRO_WINDOW + 10);
            repeat (run_len) send_sample(s);
         end else if (choice < 4) begin
            run_len = $urandom_range(5, 30);
            repeat (run_len) send_sample(make_sample(VAL_NEAR_ZERO));
         end else begin
            run_len = $urandom_range(5, 25);
            repeat (run_len) send_sample(make_sample(VAL_ANY));
         end
         sent += run_len;
         if (sent >= next_pause) begin
            go_idle();
            wait_drained();
            next_pause += 400;
         end
      end
      gaps_enabled = 1'b1;
      go_idle();
      wait_drained();
   endtask

   // Back-pressure: the receiver holds ready low for a long stretch while
   // the sender keeps offering beats without gaps, so the pipeline fills and
   // the block must stall its input without losing or repeating a beat.
   task automatic test_receiver_hold_off();
      gaps_enabled     = 1'b0;
      hold_off_request = 1'b1;
      repeat (HOLD_ITEMS) send_sample(make_sample(VAL_ANY));
      gaps_enabled = 1'b1;
      go_idle();
      wait_drained();
   endtask

   // Receiver: switches among always-ready, random stalls and a fixed
   // stall pattern, with long hold-offs on request from a test.
   always @(posedge clock) begin
      if (hold_off_request) begin
         hold_left        = HOLD_CYCLES;
         hold_off_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 2));
            mode_left  = $urandom_range(40, 250);
         end
         mode_left--;
         pattern_phase++;
         case (ready_mode)
            READY_ALWAYS: rsp_ch.ready <= 1'b1;
            READY_RANDOM: rsp_ch.ready <= ($urandom_range(0, 99) >= 30);
            default:      rsp_ch.ready <= ((pattern_phase % 5) >= 2);
         endcase
      end
   end

   // Result checker: every accepted result beat is compared field by field
   // with the oldest predicted means.
   always @(posedge clock) begin
      mean_set_type got;
      mean_set_type exp_means;
      string        bad;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.accel_mean_x = rsp_ch.accel_mean_x;
         got.accel_mean_y = rsp_ch.accel_mean_y;
         got.accel_mean_z = rsp_ch.accel_mean_z;
         got.rate_mean_x  = rsp_ch.rate_mean_x;
         got.rate_mean_y  = rsp_ch.rate_mean_y;
         got.rate_mean_z  = rsp_ch.rate_mean_z;
         if (pending_means.size() == 0) begin
            report_failure($sformatf("result beat %0d arrived with nothing pending",
                                     results_seen));
         end else begin
            exp_means = pending_means.pop_front();
            bad = "";
            if (got.accel_mean_x !== exp_means.accel_mean_x) bad = {bad, " accel_mean_x"};
            if (got.accel_mean_y !== exp_means.accel_mean_y) bad = {bad, " accel_mean_y"};
            if (got.accel_mean_z !== exp_means.accel_mean_z) bad = {bad, " accel_mean_z"};
            if (got.rate_mean_x  !== exp_means.rate_mean_x)  bad = {bad, " rate_mean_x"};
            if (got.rate_mean_y  !== exp_means.rate_mean_y)  bad = {bad, " rate_mean_y"};
            if (got.rate_mean_z  !== exp_means.rate_mean_z)  bad = {bad, " rate_mean_z"};
            if (bad != "")
               report_failure($sformatf(
                  "result %0d wrong:%s exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                  results_seen, bad,
                  $signed(exp_means.accel_mean_x), $signed(exp_means.accel_mean_y),
                  $signed(exp_means.accel_mean_z), $signed(exp_means.rate_mean_x),
                  $signed(exp_means.rate_mean_y), $signed(exp_means.rate_mean_z),
                  $signed(got.accel_mean_x), $signed(got.accel_mean_y),
                  $signed(got.accel_mean_z), $signed(got.rate_mean_x),
                  $signed(got.rate_mean_y), $signed(got.rate_mean_z)));
         end
         results_seen++;
      end
   end

   // Main sequence: reset once, run the tests, let the pipeline settle and
   // report.
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.accel_x = '0;
      req_ch.accel_y = '0;
      req_ch.accel_z = '0;
      req_ch.rate_x  = '0;
      req_ch.rate_y  = '0;
      req_ch.rate_z  = '0;
      rsp_ch.ready   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_startup_and_extremes();
      test_receiver_hold_off();
      test_random_stream(RANDOM_ITEMS);

      // Wait for any stray result beat to show up before the final check.
      repeat (NUM_STAGES * 4) @(posedge clock);
      if (failures == 0 && pending_means.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (pending_means.size() != 0)
            report_failure($sformatf("%0d results never arrived", pending_means.size()));
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
